[rtl/akpd_pkg.sv]
// Package: shared constants, register indexes and controller/datapath types for the key detector.
`default_nettype none

package akpd_pkg;

    localparam int NUM_KEYS       = 64;
    localparam int EVENT_CAPACITY = 16;
    localparam int ADC_BITS       = 12;

    localparam int KEY_W     = 6;
    localparam int SAMPLE_W  = 12;
    localparam int THR_W     = 10;
    localparam int SHIFT_W   = 4;
    localparam int Q8_W      = 20;
    localparam int TRAVEL_W  = 10;
    localparam int COUNT_W   = 32;
    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int FEV_W     = $clog2(EVENT_CAPACITY + 1);

    localparam int DIVD_W = 22;
    localparam int DIVS_W = 12;
    localparam int DCNT_W = $clog2(DIVD_W + 1);

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 112;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_RELEASED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT     = 3'd4;

    localparam logic [SAMPLE_W-1:0] RELEASED_RST  = 12'd1000;
    localparam logic [SAMPLE_W-1:0] PRESSED_RST   = 12'd3000;
    localparam logic [THR_W-1:0]    PRESS_THR_RST = 10'd450;
    localparam logic [THR_W-1:0]    REL_THR_RST   = 10'd350;
    localparam logic [SHIFT_W-1:0]  SHIFT_RST     = 4'd2;
    localparam logic [Q8_W-1:0]     FILT_RST      = {RELEASED_RST, 8'd0};

    localparam logic [TRAVEL_W-1:0] TRAVEL_FULL = 10'd1000;

    typedef struct packed {
        logic load;
        logic filter;
        logic mult;
        logic div_start;
        logic commit;
    } akpd_cmd_t;

    typedef struct packed {
        logic key_valid;
        logic div_done;
        logic commit_stall;
    } akpd_status_t;

endpackage

`default_nettype wire

[rtl/akpd_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module akpd_div
    import akpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    output logic                   done,
    output logic [DIVD_W-1:0]      quotient
);

    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVS_W])
            begin
                rem_reg <= diff[DIVS_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DIVS_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/akpd_ctrl.sv]
// Controller: sequences one sample through read, filter, multiply, divide and commit.
`default_nettype none

module akpd_ctrl
    import akpd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire akpd_status_t status,
    output akpd_cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIVL = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DEC  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && status.key_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIVL;
            ST_DIVL: state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (!status.commit_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready      = (state_reg == ST_IDLE);
    assign cmd.load      = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.filter    = (state_reg == ST_READ);
    assign cmd.mult      = (state_reg == ST_MUL);
    assign cmd.div_start = (state_reg == ST_DIVL);
    assign cmd.commit    = (state_reg == ST_DEC) && !status.commit_stall;

endmodule

`default_nettype wire

[rtl/akpd_dp.sv]
// Datapath: config registers, per-key filter memory, travel arithmetic, hysteresis and result register.
`default_nettype none

module akpd_dp
    import akpd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire akpd_cmd_t             cmd,
    output akpd_status_t               status
);

    // configuration
    logic [SAMPLE_W-1:0] rel_reg;
    logic [SAMPLE_W-1:0] prs_reg;
    logic [THR_W-1:0]    press_thr_reg;
    logic [THR_W-1:0]    rel_thr_reg;
    logic [SHIFT_W-1:0]  shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_reg       <= RELEASED_RST;
            prs_reg       <= PRESSED_RST;
            press_thr_reg <= PRESS_THR_RST;
            rel_thr_reg   <= REL_THR_RST;
            shift_reg     <= SHIFT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RELEASED:  rel_reg       <= cfg_data[SAMPLE_W-1:0];
                CFG_PRESSED:   prs_reg       <= cfg_data[SAMPLE_W-1:0];
                CFG_PRESS_THR: press_thr_reg <= cfg_data[THR_W-1:0];
                CFG_REL_THR:   rel_thr_reg   <= cfg_data[THR_W-1:0];
                CFG_SHIFT:     shift_reg     <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // input item
    logic [KEY_W-1:0]    in_key;
    logic [SAMPLE_W-1:0] in_sample;
    logic [KEY_W-1:0]    key_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [KEY_IDX_W-1:0] idx;

    assign in_key    = s_tdata[KEY_W-1:0];
    assign in_sample = s_tdata[KEY_W +: SAMPLE_W];
    assign idx       = key_reg[KEY_IDX_W-1:0];

    assign status.key_valid = ({{(32-KEY_W){1'b0}}, in_key} < 32'(NUM_KEYS));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= in_key;
            sample_reg <= in_sample & SAMPLE_W'((1 << ADC_BITS) - 1);
        end
    end

    // filter memory; unwritten entries read as the reset level
    logic [Q8_W-1:0]     filt_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] fvalid_reg;
    logic [Q8_W-1:0]     rd_q_reg;
    logic                rd_valid_reg;
    logic [Q8_W-1:0]     filt_reg;
    logic [Q8_W-1:0]     filt_next;

    logic [Q8_W-1:0]    cur;
    logic signed [21:0] fdiff;
    logic signed [21:0] fstep;
    logic signed [21:0] fsum;

    assign cur       = rd_valid_reg ? rd_q_reg : FILT_RST;
    assign fdiff     = $signed({2'b00, sample_reg, 8'd0}) - $signed({2'b00, cur});
    assign fstep     = fdiff >>> shift_reg;
    assign fsum      = $signed({2'b00, cur}) + fstep;
    assign filt_next = fsum[21] ? '0 : fsum[Q8_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_q_reg <= filt_mem[in_key[KEY_IDX_W-1:0]];
        end
        if (cmd.filter)
        begin
            filt_mem[idx] <= filt_next;
            filt_reg      <= filt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvalid_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_valid_reg <= fvalid_reg[in_key[KEY_IDX_W-1:0]];
            end
            if (cmd.filter)
            begin
                fvalid_reg[idx] <= 1'b1;
            end
        end
    end

    // travel = (level - released) * 1000 / (pressed - released)
    logic [SAMPLE_W-1:0] level;
    logic signed [12:0]  tdiff;
    logic signed [23:0]  prod_next;
    logic signed [23:0]  prod_reg;
    logic signed [23:0]  prod_neg;
    logic signed [12:0]  span;
    logic signed [12:0]  span_neg;
    logic [DIVD_W-1:0]   prod_mag;
    logic [DIVS_W-1:0]   span_mag;
    logic                neg_reg;
    logic                span_zero_reg;
    logic                div_done;
    logic [DIVD_W-1:0]   quo;

    assign level     = filt_reg[Q8_W-1:8];
    assign tdiff     = $signed({1'b0, level}) - $signed({1'b0, rel_reg});
    assign prod_next = $signed({{11{tdiff[12]}}, tdiff}) * $signed({14'd0, TRAVEL_FULL});
    assign prod_neg  = -prod_reg;
    assign prod_mag  = prod_reg[23] ? prod_neg[DIVD_W-1:0] : prod_reg[DIVD_W-1:0];
    assign span      = $signed({1'b0, prs_reg}) - $signed({1'b0, rel_reg});
    assign span_neg  = -span;
    assign span_mag  = span[12] ? span_neg[DIVS_W-1:0] : span[DIVS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.div_start)
        begin
            neg_reg       <= prod_reg[23] ^ span[12];
            span_zero_reg <= (span == 13'sd0);
        end
    end

    akpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_mag),
        .divisor  (span_mag),
        .done     (div_done),
        .quotient (quo)
    );

    assign status.div_done = div_done;

    // hysteresis and event decision
    logic [TRAVEL_W-1:0] travel;
    logic [NUM_KEYS-1:0] key_down_reg;
    logic                prev_down;
    logic                now_down;
    logic                emit;
    logic [FEV_W-1:0]    frame_events_reg;
    logic [COUNT_W-1:0]  frame_counter_reg;
    logic [COUNT_W-1:0]  event_counter_reg;
    logic                m_tvalid_reg;

    always_comb
    begin
        priority if (span_zero_reg || neg_reg)
        begin
            travel = '0;
        end
        else if (quo >= DIVD_W'(TRAVEL_FULL))
        begin
            travel = TRAVEL_FULL;
        end
        else
        begin
            travel = quo[TRAVEL_W-1:0];
        end
    end

    assign prev_down = key_down_reg[idx];
    assign now_down  = prev_down ? (travel > rel_thr_reg) : (travel >= press_thr_reg);
    assign emit      = (now_down != prev_down) && (frame_events_reg < FEV_W'(EVENT_CAPACITY));

    assign status.commit_stall = emit && m_tvalid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg      <= '0;
            frame_events_reg  <= '0;
            frame_counter_reg <= '0;
            event_counter_reg <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.commit && emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.load && s_tuser)
            begin
                frame_events_reg  <= '0;
                frame_counter_reg <= frame_counter_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                key_down_reg[idx] <= now_down;
                if (emit)
                begin
                    frame_events_reg  <= frame_events_reg + 1'b1;
                    event_counter_reg <= event_counter_reg + 1'b1;
                end
            end
        end
    end

    // result register
    logic [KEY_W-1:0]    ev_key_reg;
    logic                ev_down_reg;
    logic [SAMPLE_W-1:0] ev_sample_reg;
    logic [SAMPLE_W-1:0] ev_level_reg;
    logic [TRAVEL_W-1:0] ev_travel_reg;
    logic [COUNT_W-1:0]  ev_frame_reg;
    logic [COUNT_W-1:0]  ev_count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit && emit)
        begin
            ev_key_reg    <= key_reg;
            ev_down_reg   <= now_down;
            ev_sample_reg <= sample_reg;
            ev_level_reg  <= level;
            ev_travel_reg <= travel;
            ev_frame_reg  <= frame_counter_reg;
            ev_count_reg  <= event_counter_reg + 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, ev_count_reg, ev_frame_reg, ev_travel_reg, ev_level_reg,
                       ev_sample_reg, ev_down_reg, ev_key_reg};

    a_frame_events_cap: assert property (@(posedge clk) disable iff (!rst_n)
        frame_events_reg <= FEV_W'(EVENT_CAPACITY))
        else $error("per-frame event count above capacity");

    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(cmd.commit))
        else $error("result raised without a commit");

    a_count_with_out: assert property (@(posedge clk) disable iff (!rst_n)
        (event_counter_reg != $past(event_counter_reg)) |-> m_tvalid_reg)
        else $error("event counted without a result");

endmodule

`default_nettype wire

[rtl/analog_key_press_detector.sv]
// Top level: analog key press detector, stream in, event stream out, config write port.
`default_nettype none

// Takes one ADC sample per transfer on the s_ side, low-pass filters the key's level,
// converts it to travel per mille and applies press/release hysteresis; a change of a
// key's down state gives one result transfer on the m_ side, at most EVENT_CAPACITY
// per frame. After a transfer s_tready stays low through the filter update, multiply, divider load,
// the bit-serial divider steps (one per quotient bit), divider done and decision, so no new sample
// is taken before the previous one is through. A sample with an event to send while the previous
// result is not yet taken waits at its decision step. Config writes are always ready.

module analog_key_press_detector
    import akpd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // key_index[5:0], sample[17:6], zero fill
    input  wire logic                  s_tuser,  // frame_start
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,  // event_key[5:0], now_down[6],
                                                 // event_sample[18:7], smoothed_level[30:19],
                                                 // travel_pm[40:31], frame_number[72:41],
                                                 // events_so_far[104:73], zero fill
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    akpd_cmd_t    cmd;
    akpd_status_t status;

    assign cfg_ready = 1'b1;

    akpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    akpd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
